// File: rtl/core/bmms_pkg.sv
package bmms_pkg;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] signed_min_bits;
    logic [31:0] signed_max_bits;
    logic [31:0] unsigned_min_bits;
    logic [31:0] unsigned_max_bits;
  } out_t;

  // Final running values of one block, before the float remap.
  typedef struct packed {
    logic [31:0] smin;
    logic [31:0] smax;
    logic [31:0] umin;
    logic [31:0] umax;
  } stats_t;

  localparam logic [1:0]  KIND_FLOAT    = 2'd3;
  localparam logic [31:0] SIGN32        = 32'h8000_0000;
  // Register index, taken from paddr[2].
  localparam logic        REG_ELEM_KIND = 1'b0;

endpackage

// File: rtl/core/bmms_accum.sv
module bmms_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bmms_pkg::in_t     in_data,
  output logic              blk_valid,
  input  logic              blk_ready,
  output bmms_pkg::stats_t  blk_data
);

  logic              in_vld_r;
  bmms_pkg::in_t     in_r;
  logic              first_pending_r;
  bmms_pkg::stats_t  run_r;
  bmms_pkg::stats_t  run_nxt;
  logic              blk_vld_r;
  bmms_pkg::stats_t  blk_r;
  logic              blk_free;
  logic              adv;
  logic [31:0]       w;

  assign w        = in_r.word;
  assign blk_free = !blk_vld_r || blk_ready;
  // a non-last word never waits on the block stage
  assign adv      = in_vld_r && (!in_r.last || blk_free);
  assign in_ready = !in_vld_r || adv;

  always_comb begin
    run_nxt = run_r;
    if (first_pending_r) begin
      run_nxt.smin = w;
      run_nxt.smax = w;
      run_nxt.umin = w;
      run_nxt.umax = w;
    end else begin
      if ($signed(w) < $signed(run_r.smin)) run_nxt.smin = w;
      if ($signed(w) > $signed(run_r.smax)) run_nxt.smax = w;
      if (w < run_r.umin) run_nxt.umin = w;
      if (w > run_r.umax) run_nxt.umax = w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r        <= 1'b0;
      first_pending_r <= 1'b1;
      blk_vld_r       <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        first_pending_r <= in_r.last;
      end
      if (adv && in_r.last) begin
        blk_vld_r <= 1'b1;
      end else if (blk_ready) begin
        blk_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (adv) begin
      run_r <= run_nxt;
    end
    if (adv && in_r.last) begin
      blk_r <= run_nxt;
    end
  end

  assign blk_valid = blk_vld_r;
  assign blk_data  = blk_r;

  a_last_makes_block: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_r.last |=> blk_vld_r)
    else $error("last word did not produce a block result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_vld_r && in_r.last && blk_vld_r)
    else $error("input stalled without a pending last word");

  a_block_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    blk_vld_r |-> (blk_r.umin <= blk_r.umax) && ($signed(blk_r.smin) <= $signed(blk_r.smax)))
    else $error("block minimum above maximum");

  a_seed_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_r.last |=> first_pending_r)
    else $error("next block not seeded");

endmodule

// File: rtl/core/bmms_remap.sv
module bmms_remap (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        elem_kind,
  input  logic              blk_valid,
  output logic              blk_ready,
  input  bmms_pkg::stats_t  blk_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bmms_pkg::out_t    out_data
);

  logic            out_vld_r;
  bmms_pkg::out_t  out_r;
  bmms_pkg::out_t  out_nxt;
  logic [31:0]     negmag;
  logic [31:0]     fminmag;

  assign blk_ready = !out_vld_r || out_ready;
  assign negmag    = blk_data.smin ^ bmms_pkg::SIGN32;
  assign fminmag   = blk_data.umax ^ bmms_pkg::SIGN32;

  always_comb begin
    out_nxt.result_kind       = elem_kind;
    out_nxt.signed_min_bits   = blk_data.smin;
    out_nxt.signed_max_bits   = blk_data.smax;
    out_nxt.unsigned_min_bits = blk_data.umin;
    out_nxt.unsigned_max_bits = blk_data.umax;
    priority if (elem_kind == bmms_pkg::KIND_FLOAT && blk_data.smax[31]) begin
      // all negative: larger pattern is the smaller float
      out_nxt.signed_min_bits   = blk_data.umax;
      out_nxt.signed_max_bits   = blk_data.umin;
      out_nxt.unsigned_min_bits = blk_data.umin ^ bmms_pkg::SIGN32;
      out_nxt.unsigned_max_bits = fminmag;
    end else if (elem_kind == bmms_pkg::KIND_FLOAT && blk_data.smin[31]) begin
      out_nxt.signed_min_bits   = blk_data.umax;
      out_nxt.signed_max_bits   = blk_data.smax;
      out_nxt.unsigned_min_bits = (blk_data.umin < negmag) ? blk_data.umin : negmag;
      out_nxt.unsigned_max_bits = (blk_data.smax > fminmag) ? blk_data.smax : fminmag;
    end else begin
      out_nxt.result_kind = elem_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (blk_valid && blk_ready) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_valid && blk_ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/block_min_max_statistics_core.sv
// A block's result passes through the input, block and result registers before out_valid.
// Throughput: one word per cycle while in_ready is high; input, block and result registers each hold one request.
// A last word waits only while a finished block and a result are both unclaimed.
// Reset (rst_n low, synchronous): all valids clear, the next word seeds a block, elem_kind = 0.
// Running min/max and result data registers are not reset.
module block_min_max_statistics_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bmms_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bmms_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  logic              blk_valid;
  logic              blk_ready;
  bmms_pkg::stats_t  blk_data;
  logic [1:0]        elem_kind_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bmms_pkg::REG_ELEM_KIND) ? {30'd0, elem_kind_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_kind_r <= 2'd0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == bmms_pkg::REG_ELEM_KIND) begin
      elem_kind_r <= pwdata[1:0];
    end
  end

  bmms_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk_data  (blk_data)
  );

  bmms_remap u_remap (
    .clk       (clk),
    .rst_n     (rst_n),
    .elem_kind (elem_kind_r),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk_data  (blk_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: bench/testbench.sv
module testbench;

  localparam logic [1:0]  KIND_RAW       = 2'd0;
  localparam logic [1:0]  KIND_INT       = 2'd1;
  localparam logic [1:0]  KIND_UINT      = 2'd2;
  localparam logic [2:0]  ADDR_ELEM_KIND = 3'd0;
  localparam logic [2:0]  ADDR_UNUSED    = 3'd4;
  localparam int          PHASE_WORDS    = 75;

  localparam int unsigned SIGN_ANY = 0;
  localparam int unsigned SIGN_NEG = 1;
  localparam int unsigned SIGN_POS = 2;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  bmms_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  bmms_pkg::out_t out_data;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  block_min_max_statistics_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // requests waiting to be driven, and block summaries waiting to come out
  bmms_pkg::in_t  word_q[$];
  bmms_pkg::out_t block_summary_q[$];

  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  bit          req_taken = 1'b0;
  bit          calm = 1'b0;

  // shadow of the block's state
  logic [1:0]  kind_shadow = KIND_RAW;
  bit          seed_next = 1'b1;
  logic [31:0] acc_smin, acc_smax, acc_umin, acc_umax;

  function automatic void fold_word(input bmms_pkg::in_t item);
    bmms_pkg::out_t sum;
    logic [31:0]    neg_mag, fmin_mag;
    if (seed_next) begin
      acc_smin = item.word;
      acc_smax = item.word;
      acc_umin = item.word;
      acc_umax = item.word;
      seed_next = 1'b0;
    end else begin
      if ($signed(item.word) < $signed(acc_smin)) acc_smin = item.word;
      if ($signed(item.word) > $signed(acc_smax)) acc_smax = item.word;
      if (item.word < acc_umin) acc_umin = item.word;
      if (item.word > acc_umax) acc_umax = item.word;
    end
    if (!item.last) return;
    seed_next = 1'b1;
    sum.result_kind       = kind_shadow;
    sum.signed_min_bits   = acc_smin;
    sum.signed_max_bits   = acc_smax;
    sum.unsigned_min_bits = acc_umin;
    sum.unsigned_max_bits = acc_umax;
    if (kind_shadow == bmms_pkg::KIND_FLOAT && acc_smax[31]) begin
      // all negative: larger pattern is the more negative float
      sum.signed_min_bits   = acc_umax;
      sum.signed_max_bits   = acc_umin;
      sum.unsigned_min_bits = acc_umin ^ bmms_pkg::SIGN32;
      sum.unsigned_max_bits = acc_umax ^ bmms_pkg::SIGN32;
    end else if (kind_shadow == bmms_pkg::KIND_FLOAT && acc_smin[31]) begin
      neg_mag  = acc_smin ^ bmms_pkg::SIGN32;
      fmin_mag = acc_umax ^ bmms_pkg::SIGN32;
      sum.signed_min_bits   = acc_umax;
      sum.signed_max_bits   = acc_smax;
      sum.unsigned_min_bits = (acc_umin < neg_mag) ? acc_umin : neg_mag;
      sum.unsigned_max_bits = (acc_smax > fmin_mag) ? acc_smax : fmin_mag;
    end
    block_summary_q.push_back(sum);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (word_q.size() != 0) begin
        in_data  <= word_q.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (out_stall != 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_stall = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    bmms_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        fold_word(in_data);
        words_taken++;
        req_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (block_summary_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time, out_data);
          mismatch_count++;
        end else begin
          want = block_summary_q.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_data.result_kind));
          check_field("signed_min_bits", want.signed_min_bits, out_data.signed_min_bits);
          check_field("signed_max_bits", want.signed_max_bits, out_data.signed_max_bits);
          check_field("unsigned_min_bits", want.unsigned_min_bits,
                      out_data.unsigned_min_bits);
          check_field("unsigned_max_bits", want.unsigned_max_bits,
                      out_data.unsigned_max_bits);
        end
      end
    end
  end

  task automatic queue_word(input logic [31:0] w, input logic last);
    bmms_pkg::in_t item;
    item.word = w;
    item.last = last;
    word_q.push_back(item);
    words_queued++;
  endtask

  function automatic logic [31:0] pick_word(input int unsigned sign_mode);
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: w = 32'h0000_0000;
          1: w = 32'hFFFF_FFFF;
          2: w = 32'h7FFF_FFFF;
          default: w = 32'h8000_0000;
        endcase
      end
      1: w = {1'b0, 8'($urandom_range(120, 134)), 23'($urandom)};
      2: w = $urandom_range(0, 15);
      default: w = $urandom;
    endcase
    if (sign_mode == SIGN_NEG) w[31] = 1'b1;
    else if (sign_mode == SIGN_POS) w[31] = 1'b0;
    return w;
  endfunction

  // one block of random words; mostly short, a few long
  task automatic queue_block(input int unsigned len, input int unsigned sign_mode);
    for (int unsigned i = 0; i < len; i++) queue_word(pick_word(sign_mode), i == len - 1);
  endtask

  // wait for every request taken and every result seen, then the pipeline tail
  task automatic drain();
    do @(negedge clk); while (words_taken != words_queued || block_summary_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_ELEM_KIND) kind_shadow = value[1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [1:0]  phase_kind;
    int unsigned phase_start;
    int unsigned len;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // raw kind from reset: one-word blocks at the extremes, then a mixed block
    queue_word(32'h0000_0000, 1'b1);
    queue_word(32'hFFFF_FFFF, 1'b1);
    queue_word(32'h7FFF_FFFF, 1'b0);
    queue_word(32'h8000_0000, 1'b0);
    queue_word(32'h0000_0000, 1'b0);
    queue_word(32'hFFFF_FFFF, 1'b1);
    drain();

    write_reg(ADDR_ELEM_KIND, {30'd0, bmms_pkg::KIND_FLOAT});
    // all negative, with negative zero
    queue_word(32'hBF80_0000, 1'b0);
    queue_word(32'hC000_0000, 1'b0);
    queue_word(32'h8000_0000, 1'b1);
    // mixed signs
    queue_word(32'h3F80_0000, 1'b0);
    queue_word(32'hBF80_0000, 1'b0);
    queue_word(32'h0000_0000, 1'b0);
    queue_word(32'h8000_0001, 1'b1);
    // positive only, with a NaN
    queue_word(32'h3F80_0000, 1'b0);
    queue_word(32'h7FC0_0000, 1'b1);
    // single negative infinity
    queue_word(32'hFF80_0000, 1'b1);
    // negative NaN against a tiny positive value
    queue_word(32'hFFC0_0000, 1'b0);
    queue_word(32'h0000_0001, 1'b1);
    drain();

    // a write beyond the only register must change nothing
    write_reg(ADDR_UNUSED, 32'h0000_0001);
    queue_word(32'h9234_5678, 1'b0);
    queue_word(32'h1234_5678, 1'b1);
    drain();

    write_reg(ADDR_ELEM_KIND, {30'd0, KIND_INT});
    queue_word(32'h8000_0000, 1'b0);
    queue_word(32'h7FFF_FFFF, 1'b1);
    drain();
    write_reg(ADDR_ELEM_KIND, {30'd0, KIND_UINT});
    queue_word(32'hFFFF_FFFF, 1'b0);
    queue_word(32'h0000_0001, 1'b1);
    drain();

    // random phases, each under a data kind written at its start
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: phase_kind = KIND_INT;
        1: phase_kind = bmms_pkg::KIND_FLOAT;
        2: phase_kind = KIND_RAW;
        3: phase_kind = KIND_UINT;
        7: phase_kind = bmms_pkg::KIND_FLOAT;
        default: phase_kind = 2'($urandom_range(0, 3));
      endcase
      write_reg(ADDR_ELEM_KIND, {30'd0, phase_kind});
      if (phase == 7) calm = 1'b1;
      phase_start = words_queued;
      while (words_queued - phase_start < PHASE_WORDS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        queue_block(len, $urandom_range(0, 3) == 3 ? SIGN_ANY : $urandom_range(0, 2));
      end
      // phase 4 also holds off mid-phase until every result is back
      if (phase == 4) begin
        drain();
        queue_block($urandom_range(1, 8), SIGN_NEG);
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // roughly 650 requests plus register writes must finish before this timeout
  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
